FILE: sv/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and fixed constants of the layer coincidence trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

  // Number of channel groups; a channel maps to group (channel mod 16) / 2.
  localparam int NUM_GROUPS   = 8;
  localparam int GROUP_IDX_W  = $clog2(NUM_GROUPS);
  // Boards that take part in the four-layer test.
  localparam int NUM_BOARDS   = 4;
  localparam int BOARD_IDX_W  = $clog2(NUM_BOARDS);

  localparam int CHANNEL_W    = 8;
  localparam int LAYER_W      = 3;
  localparam int BOARD_W      = 4;
  localparam int HIT_TYPE_W   = 2;
  localparam int CFG_W        = 4;
  localparam int COUNT_W      = 3;

  // Hit kind that feeds the masks.
  localparam logic [HIT_TYPE_W-1:0] HIT_TYPE_BAR = 2'd0;

  // Saturation point of the hit counter and the per-trigger minimums.
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 3'd7;
  localparam logic [COUNT_W-1:0] MIN_HITS_FOUR   = 3'd4;
  localparam logic [COUNT_W-1:0] MIN_HITS_THREE  = 3'd3;
  localparam logic [COUNT_W-1:0] MIN_HITS_TWO    = 3'd2;

  localparam logic [CFG_W-1:0] MIN_GROUP_LAYERS_RST = 4'd3;

  // Stream word widths; the data widths are padded to whole bytes.
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 8;

  typedef struct packed {
    logic                  hit_present;
    logic [CHANNEL_W-1:0]  channel;
    logic [LAYER_W-1:0]    layer;
    logic [BOARD_W-1:0]    board;
    logic [HIT_TYPE_W-1:0] hit_type;
    logic                  last_hit;
  } hit_t;

  typedef struct packed {
    logic two_adjacent;
    logic two_separate;
    logic three_in_row;
    logic four_layers;
  } trig_t;

endpackage

`default_nettype wire

FILE: sv/lct_in_reg.sv
// ----------------------------------------------------------------------------
// lct_in_reg
// Input register stage: captures one hit word and holds it until consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lct_pkg::hit_t in_item,
  input  wire logic          consume,
  output logic               item_valid,
  output lct_pkg::hit_t      item
);
  import lct_pkg::*;

  // The stage refills in the same cycle that it is drained.
  assign in_ready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lct_accum.sv
// ----------------------------------------------------------------------------
// lct_accum
// Event accumulator: updates hit count and masks, evaluates the triggers.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_accum #(
  parameter int NUM_LAYERS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lct_pkg::CFG_W-1:0]   min_group_layers,
  input  wire logic                        fire,
  input  wire lct_pkg::hit_t               item,
  output lct_pkg::trig_t                   trig
);
  import lct_pkg::*;

  logic [COUNT_W-1:0]    hit_count;
  logic [NUM_BOARDS-1:0] board_mask;
  logic [NUM_LAYERS-1:0] layer_mask;
  logic [NUM_LAYERS-1:0] group_masks [NUM_GROUPS];

  logic [COUNT_W-1:0]    hit_count_next;
  logic [NUM_BOARDS-1:0] board_mask_next;
  logic [NUM_LAYERS-1:0] layer_mask_next;
  logic [NUM_LAYERS-1:0] group_masks_next [NUM_GROUPS];

  logic                   is_bar;
  logic                   board_ok;
  logic                   layer_ok;
  logic [GROUP_IDX_W-1:0] group;
  logic [NUM_LAYERS-1:0]  layer_bit;
  logic                   group_hit;
  logic                   span_wide;

  assign is_bar    = item.hit_present && (item.hit_type == HIT_TYPE_BAR);
  assign board_ok  = int'(item.board) < NUM_BOARDS;
  assign layer_ok  = int'(item.layer) < NUM_LAYERS;
  assign group     = item.channel[GROUP_IDX_W:1];
  assign layer_bit = NUM_LAYERS'(1) << item.layer;

  always_comb begin
    hit_count_next  = hit_count;
    board_mask_next = board_mask;
    layer_mask_next = layer_mask;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_masks_next[g] = group_masks[g];
    end
    if (item.hit_present && hit_count != COUNT_MAX) begin
      hit_count_next = hit_count + COUNT_W'(1);
    end
    if (is_bar && board_ok) begin
      board_mask_next[item.board[BOARD_IDX_W-1:0]] = 1'b1;
    end
    if (is_bar && layer_ok) begin
      layer_mask_next         = layer_mask | layer_bit;
      group_masks_next[group] = group_masks[group] | layer_bit;
    end
  end

  // Trigger evaluation on the state that includes the current hit.
  always_comb begin
    group_hit = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if ($countones(group_masks_next[g]) >= int'(min_group_layers)) begin
        group_hit = 1'b1;
      end
    end
    // Two set layers at least two apart: some set bit has another set bit
    // two or more positions above it.
    span_wide = 1'b0;
    for (int i = 0; i + 2 < NUM_LAYERS; i++) begin
      if (layer_mask_next[i] && (|(layer_mask_next >> (i + 2)))) begin
        span_wide = 1'b1;
      end
    end
  end

  assign trig.four_layers  = (hit_count_next >= MIN_HITS_FOUR) && (&board_mask_next);
  assign trig.three_in_row = (hit_count_next >= MIN_HITS_THREE) && group_hit;
  assign trig.two_separate = (hit_count_next >= MIN_HITS_TWO) && span_wide;
  assign trig.two_adjacent = (hit_count_next >= MIN_HITS_TWO)
                             && (|(layer_mask_next & (layer_mask_next >> 1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count  <= '0;
      board_mask <= '0;
      layer_mask <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        group_masks[g] <= '0;
      end
    end else if (fire) begin
      if (item.last_hit) begin
        hit_count  <= '0;
        board_mask <= '0;
        layer_mask <= '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
          group_masks[g] <= '0;
        end
      end else begin
        hit_count  <= hit_count_next;
        board_mask <= board_mask_next;
        layer_mask <= layer_mask_next;
        for (int g = 0; g < NUM_GROUPS; g++) begin
          group_masks[g] <= group_masks_next[g];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lct_out_reg.sv
// ----------------------------------------------------------------------------
// lct_out_reg
// Result register: holds one trigger word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire lct_pkg::trig_t load_trig,
  output logic                slot_free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lct_pkg::trig_t      out_trig
);
  import lct_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      out_trig <= load_trig;
    end
  end

endmodule

`default_nettype wire

FILE: sv/layer_coincidence_trigger_core.sv
// ----------------------------------------------------------------------------
// layer_coincidence_trigger_core
// Per-event layer coincidence trigger over a stream of detector hits.
// ----------------------------------------------------------------------------
// The core takes the hits of one event as a stream of words, one hit per word,
// and closes the event on the word that carries tlast; a word with no hit
// (hit_present low) and tlast set closes the event without adding a hit, and
// one without tlast is ignored. For each closed event it sends one result word
// with four trigger bits, then starts the next event from a clean state. The
// core sustains one input word per clock cycle with no gaps between events
// while result words are taken. A result word passes through the input
// register and the result register, which bracket the combinational update
// and evaluation logic; a stalled result word holds the pipeline only when the
// next closing word reaches the evaluation stage. Only bar hits (hit_type 0)
// set the board, layer and channel-group masks, while the hit-count minimums
// count every hit. The min_group_layers register (reset value 3) sets how many
// distinct layers one channel group must show for three_in_row; it is written
// through the cfg channel and should only be changed while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_coincidence_trigger_core #(
  parameter int NUM_LAYERS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Hit words in.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [7:0] channel, [10:8] layer, [14:11] board, [15] zero
  input  wire logic [lct_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] hit_present, [2:1] hit_type
  input  wire logic [lct_pkg::S_TUSER_W-1:0]   s_tuser,
  input  wire logic                            s_tlast,
  // Trigger words out.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] four_layers, [1] three_in_row, [2] two_separate, [3] two_adjacent,
  // [7:4] zero
  output logic [lct_pkg::M_TDATA_W-1:0]        m_tdata,
  // Configuration write channel for min_group_layers.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lct_pkg::CFG_W-1:0]       cfg_data
);
  import lct_pkg::*;

  hit_t             in_item;
  hit_t             item;
  logic             item_valid;
  logic             fire;
  logic             slot_free;
  trig_t            trig;
  trig_t            out_trig;
  logic [CFG_W-1:0] min_group_layers;

  // Unpack the stream word into the hit fields.
  assign in_item.hit_present = s_tuser[0];
  assign in_item.hit_type    = s_tuser[2:1];
  assign in_item.channel     = s_tdata[7:0];
  assign in_item.layer       = s_tdata[10:8];
  assign in_item.board       = s_tdata[14:11];
  assign in_item.last_hit    = s_tlast;

  // The configuration register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_group_layers <= MIN_GROUP_LAYERS_RST;
    end else if (cfg_valid) begin
      min_group_layers <= cfg_data;
    end
  end

  lct_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .consume    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  // A word that does not close an event never waits; a closing word waits
  // until the result register has room for its trigger word.
  assign fire = item_valid && (!item.last_hit || slot_free);

  lct_accum #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_accum (
    .clk              (clk),
    .rst              (rst),
    .min_group_layers (min_group_layers),
    .fire             (fire),
    .item             (item),
    .trig             (trig)
  );

  lct_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && item.last_hit),
    .load_trig (trig),
    .slot_free (slot_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_trig  (out_trig)
  );

  assign m_tdata = {4'b0000, out_trig.two_adjacent, out_trig.two_separate,
                    out_trig.three_in_row, out_trig.four_layers};

endmodule

`default_nettype wire

FILE: sv/lct_checker.sv
// ----------------------------------------------------------------------------
// lct_checker
// Port-level checks of the layer coincidence trigger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [lct_pkg::M_TDATA_W-1:0] m_tdata
);

  // After reset both register stages are empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  // Padding bits of a result word are zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'b0000)
    else $error("result word padding not zero");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // With the result side drained, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

bind layer_coincidence_trigger_core lct_checker u_lct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
